// ===== sv/mmce_pkg.sv =====
// ----------------------------------------------------------------------------
// mmce_pkg
// Types, constants and byte update functions of the multi-mode checksum engine.
// ----------------------------------------------------------------------------
package mmce_pkg;

	localparam int CSUM_W = 32;
	localparam int BYTE_W = 8;
	localparam int LEN_W  = 3;
	localparam int CIDX_W = 2;

	typedef enum logic [2:0] {
		MODE_SUM,
		MODE_XOR,
		MODE_CRC8,
		MODE_ARC,
		MODE_CCITT,
		MODE_MODBUS,
		MODE_CRC32,
		MODE_CRC32C
	} mode_t;

	typedef logic [CIDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t REG_MODE      = 2'd0;
	localparam cfg_idx_t REG_CRC8_POLY = 2'd1;
	localparam cfg_idx_t REG_CRC8_INIT = 2'd2;

	typedef logic [LEN_W-1:0] len_t;
	localparam len_t LEN_1 = 3'd1;
	localparam len_t LEN_2 = 3'd2;
	localparam len_t LEN_4 = 3'd4;

	localparam logic [15:0] POLY_ARC_REFL    = 16'hA001;
	localparam logic [15:0] POLY_CCITT       = 16'h1021;
	localparam logic [31:0] POLY_CRC32_REFL  = 32'hEDB88320;
	localparam logic [31:0] POLY_CRC32C_REFL = 32'h82F63B78;
	localparam logic [15:0] ONES16           = 16'hFFFF;
	localparam logic [31:0] ONES32           = 32'hFFFFFFFF;

	localparam logic [7:0] CRC8_POLY_RST = 8'h07;
	localparam logic [7:0] CRC8_INIT_RST = 8'h00;

	function automatic logic [31:0] crc_refl(logic [31:0] acc, logic [7:0] bt,
			logic [31:0] poly);
		logic [31:0] a;
		a = acc ^ {24'd0, bt};
		for (int i = 0; i < 8; i++) begin
			a = a[0] ? ((a >> 1) ^ poly) : (a >> 1);
		end
		return a;
	endfunction

	function automatic logic [7:0] crc8_msb(logic [7:0] acc, logic [7:0] bt,
			logic [7:0] poly);
		logic [7:0] a;
		a = acc ^ bt;
		for (int i = 0; i < 8; i++) begin
			a = a[7] ? ((a << 1) ^ poly) : (a << 1);
		end
		return a;
	endfunction

	function automatic logic [15:0] crc16_msb(logic [15:0] acc, logic [7:0] bt);
		logic [15:0] a;
		a = acc ^ {bt, 8'd0};
		for (int i = 0; i < 8; i++) begin
			a = a[15] ? ((a << 1) ^ POLY_CCITT) : (a << 1);
		end
		return a;
	endfunction

	function automatic logic [31:0] start_value(mode_t m, logic [7:0] init8);
		logic [31:0] r;
		unique case (m)
			MODE_CRC8:               r = {24'd0, init8};
			MODE_CCITT, MODE_MODBUS: r = {16'd0, ONES16};
			MODE_CRC32, MODE_CRC32C: r = ONES32;
			default:                 r = '0;
		endcase
		return r;
	endfunction

	function automatic logic [31:0] width_mask(mode_t m);
		logic [31:0] r;
		unique case (m)
			MODE_SUM, MODE_XOR, MODE_CRC8:     r = 32'h0000_00FF;
			MODE_ARC, MODE_CCITT, MODE_MODBUS: r = {16'd0, ONES16};
			default:                           r = ONES32;
		endcase
		return r;
	endfunction

	function automatic len_t result_len(mode_t m);
		len_t r;
		unique case (m)
			MODE_SUM, MODE_XOR, MODE_CRC8:     r = LEN_1;
			MODE_ARC, MODE_CCITT, MODE_MODBUS: r = LEN_2;
			default:                           r = LEN_4;
		endcase
		return r;
	endfunction

	function automatic logic [31:0] out_xor(mode_t m);
		return (m == MODE_CRC32 || m == MODE_CRC32C) ? ONES32 : 32'd0;
	endfunction

	function automatic logic [31:0] fold_byte(mode_t m, logic [31:0] acc,
			logic [7:0] bt, logic [7:0] poly8);
		logic [31:0] t;
		logic [31:0] r;
		t = '0;
		unique case (m)
			MODE_SUM:   r = {24'd0, 8'(acc[7:0] + bt)};
			MODE_XOR:   r = {24'd0, acc[7:0] ^ bt};
			MODE_CRC8:  r = {24'd0, crc8_msb(acc[7:0], bt, poly8)};
			MODE_CCITT: r = {16'd0, crc16_msb(acc[15:0], bt)};
			MODE_ARC, MODE_MODBUS: begin
				t = crc_refl({16'd0, acc[15:0]}, bt, {16'd0, POLY_ARC_REFL});
				r = {16'd0, t[15:0]};
			end
			MODE_CRC32: r = crc_refl(acc, bt, POLY_CRC32_REFL);
			default:    r = crc_refl(acc, bt, POLY_CRC32C_REFL);
		endcase
		return r;
	endfunction

endpackage

// ===== sv/mmce_msg_if.sv =====
// ----------------------------------------------------------------------------
// mmce_msg_if
// Message byte channel: one byte, its valid flag and end of message.
// ----------------------------------------------------------------------------
interface mmce_msg_if;
	logic                        valid;
	logic                        ready;
	logic [mmce_pkg::BYTE_W-1:0] data_byte;
	logic                        byte_valid;
	logic                        last;

	modport source (output valid, data_byte, byte_valid, last, input ready);
	modport sink   (input valid, data_byte, byte_valid, last, output ready);
endinterface

// ===== sv/mmce_res_if.sv =====
// ----------------------------------------------------------------------------
// mmce_res_if
// Result channel: final checksum and its length in bytes.
// ----------------------------------------------------------------------------
interface mmce_res_if;
	logic                        valid;
	logic                        ready;
	logic [mmce_pkg::CSUM_W-1:0] checksum;
	logic [mmce_pkg::LEN_W-1:0]  result_bytes;

	modport source (output valid, checksum, result_bytes, input ready);
	modport sink   (input valid, checksum, result_bytes, output ready);
endinterface

// ===== sv/mmce_cfg_if.sv =====
// ----------------------------------------------------------------------------
// mmce_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface mmce_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [mmce_pkg::CIDX_W-1:0] index;
	logic [mmce_pkg::BYTE_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/multi_mode_checksum_engine_core.sv =====
// ----------------------------------------------------------------------------
// multi_mode_checksum_engine_core
// Running sum, xor or CRC over a byte stream, one byte per cycle unless the input stage stalls.
// ----------------------------------------------------------------------------
// Takes one byte per cycle while not stalled: a transfer on msg is registered,
// then folded into the running value by an unrolled eight-bit update, and a
// transfer with last places the final checksum in the output register, so a
// result passes the input register and then the output register.
// The only stall is an item with last meeting a result still held in the
// output register. Registers: 0 mode, 1 crc8_poly, 2 crc8_init; write them
// only while the block is idle. Writes to index 3 are ignored.
module multi_mode_checksum_engine_core (
	input logic        clk,
	input logic        arst_n,
	mmce_msg_if.sink   msg,
	mmce_res_if.source res,
	mmce_cfg_if.sink   cfg
);

	mmce_pkg::mode_t mode_q;
	logic [7:0]      crc8_poly_q;
	logic [7:0]      crc8_init_q;

	logic [31:0] running_q;
	logic        started_q;

	logic       valid_s1;
	logic [7:0] data_byte_s1;
	logic       byte_valid_s1;
	logic       last_s1;

	logic        s1_go;
	logic        s1_fire;
	logic [31:0] cur_val;
	logic [31:0] nxt_val;
	logic [31:0] fin_val;

	logic                 res_valid_q;
	logic [31:0]          checksum_q;
	mmce_pkg::len_t       result_bytes_q;

	// configuration
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= mmce_pkg::MODE_SUM;
			crc8_poly_q <= mmce_pkg::CRC8_POLY_RST;
			crc8_init_q <= mmce_pkg::CRC8_INIT_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				mmce_pkg::REG_MODE:      mode_q      <= mmce_pkg::mode_t'(cfg.data[2:0]);
				mmce_pkg::REG_CRC8_POLY: crc8_poly_q <= cfg.data;
				mmce_pkg::REG_CRC8_INIT: crc8_init_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// handshake
	assign s1_go     = !valid_s1 || !last_s1 || !res_valid_q || res.ready;
	assign s1_fire   = valid_s1 && s1_go;
	assign msg.ready = s1_go;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_go) begin
			valid_s1 <= msg.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && msg.valid) begin
			data_byte_s1  <= msg.data_byte;
			byte_valid_s1 <= msg.byte_valid;
			last_s1       <= msg.last;
		end
	end

	// byte update
	always_comb begin
		cur_val = started_q ? (running_q & mmce_pkg::width_mask(mode_q))
		                    : mmce_pkg::start_value(mode_q, crc8_init_q);
		nxt_val = mmce_pkg::fold_byte(mode_q, cur_val, data_byte_s1, crc8_poly_q);
		fin_val = ((byte_valid_s1 ? nxt_val : cur_val) & mmce_pkg::width_mask(mode_q))
		          ^ mmce_pkg::out_xor(mode_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= '0;
			started_q <= 1'b0;
		end else if (s1_fire) begin
			if (last_s1) begin
				started_q <= 1'b0;
			end else if (byte_valid_s1) begin
				running_q <= nxt_val;
				started_q <= 1'b1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (s1_fire && last_s1) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && last_s1) begin
			checksum_q     <= fin_val;
			result_bytes_q <= mmce_pkg::result_len(mode_q);
		end
	end

	assign res.valid        = res_valid_q;
	assign res.checksum     = checksum_q;
	assign res.result_bytes = result_bytes_q;

	// checks
	a_stall_only_on_full_out: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !s1_go) |-> (last_s1 && res_valid_q))
		else $error("input stage stalled without a pending result");

	a_end_clears_started: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_fire && last_s1) |=> !started_q)
		else $error("message not restarted after last");

	a_len_legal: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (res.result_bytes == mmce_pkg::LEN_1 ||
		               res.result_bytes == mmce_pkg::LEN_2 ||
		               res.result_bytes == mmce_pkg::LEN_4))
		else $error("illegal result length");

	a_narrow_upper_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.result_bytes != mmce_pkg::LEN_4) |->
		(res.checksum[31:16] == 16'd0))
		else $error("narrow checksum has upper bits set");

endmodule
